FILE: rtl/core/jpeg_marker_structure_checker_top_assert.svh
// ----------------------------------------------------------------------------
// JPEG marker structure checker - assertion macros
// Concurrent assertion helpers clocked on clk with asynchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef JPEG_MARKER_STRUCTURE_CHECKER_TOP_ASSERT_SVH
`define JPEG_MARKER_STRUCTURE_CHECKER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define JMSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define JMSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define JMSC_ASSERT_NOW(label, ante, cons, msg)
`define JMSC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/core/jmsc_pkg.sv
// ----------------------------------------------------------------------------
// jmsc_pkg
// Shared constants and types of the JPEG marker structure checker.
// ----------------------------------------------------------------------------
package jmsc_pkg;

    // Marker bytes
    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] MARKER_SOI    = 8'hD8;
    localparam logic [7:0] MARKER_EOI    = 8'hD9;
    localparam logic [7:0] MARKER_SOS    = 8'hDA;
    localparam logic [7:0] MARKER_TEM    = 8'h01;
    localparam logic [7:0] MARKER_RST0   = 8'hD0;
    localparam logic [7:0] MARKER_RST7   = 8'hD7;
    localparam logic [7:0] STUFF_BYTE    = 8'h00;

    // Minimum file size and byte counter width
    localparam int unsigned MIN_FILE_BYTES = 5;
    localparam int unsigned COUNT_W        = $clog2(MIN_FILE_BYTES + 1);

    // Fault codes
    typedef enum logic [2:0] {
        FAULT_OK     = 3'd0,
        FAULT_SHORT  = 3'd1,
        FAULT_SOI    = 3'd2,
        FAULT_MARKER = 3'd3,
        FAULT_LENGTH = 3'd4,
        FAULT_TRUNC  = 3'd5,
        FAULT_TRAIL  = 3'd6
    } fault_t;

endpackage

FILE: rtl/core/jpeg_marker_structure_checker_top.sv
// ----------------------------------------------------------------------------
// jpeg_marker_structure_checker_top
// Byte-stream checker of JPEG marker structure with a verdict on the last byte.
// ----------------------------------------------------------------------------
// Takes one byte of a JPEG file per cycle when not stalled, and checks the
// marker structure: SOI first, fill runs, standalone markers, length-prefixed segments
// and entropy data after SOS. A byte is captured in an input register and
// from there updates the parser state; a final byte instead clears the parser
// and loads its verdict into the result register. Non-final bytes produce no
// result. The only stall comes from the result register: a final byte waits in
// the input register while an earlier verdict has not been taken. After the
// verdict the parser returns to its reset state, ready for the next file.
// ----------------------------------------------------------------------------
`include "jpeg_marker_structure_checker_top_assert.svh"

module jpeg_marker_structure_checker_top
    import jmsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // byte channel
    input  logic       data_valid,
    output logic       data_ready,
    input  logic [7:0] data_byte,
    input  logic       is_final,
    // verdict channel
    output logic       result_valid,
    input  logic       result_ready,
    output logic       structure_ok,
    output logic [2:0] fault_code
);

    typedef enum logic [3:0] {
        PH_SOI0,
        PH_SOI1,
        PH_MARK,
        PH_FILL,
        PH_LENHI,
        PH_LENLO,
        PH_SKIP,
        PH_ENT,
        PH_ENTFF,
        PH_DONE,
        PH_FAULT
    } phase_t;

    // Outcome of a marker code
    typedef struct packed {
        phase_t phase;
        logic   scan;
        logic   eoi;
    } marker_act_t;

    function automatic marker_act_t take_marker(input logic [7:0] m, input logic scan);
        marker_act_t act;
        act.phase = PH_LENHI;
        act.scan  = 1'b0;
        act.eoi   = 1'b0;
        if (m == MARKER_EOI) begin
            act.phase = PH_DONE;
            act.scan  = scan;
            act.eoi   = 1'b1;
        end else if (m == MARKER_SOS) begin
            act.scan  = 1'b1;
        end else if (m >= MARKER_RST0 && m <= MARKER_RST7) begin
            act.phase = scan ? PH_ENT : PH_MARK;
            act.scan  = scan;
        end else if (m == MARKER_TEM) begin
            act.phase = PH_MARK;
        end
        return act;
    endfunction

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_final_reg;

    // Parser state
    phase_t             phase_reg,  phase_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [15:0]        remain_reg, remain_next;
    logic [7:0]         len_hi_reg, len_hi_next;
    logic               scan_reg,   scan_next;
    fault_t             fault_reg,  fault_next;
    logic               eoi_reg,    eoi_next;

    // Result stage
    logic       out_valid_reg;
    logic       ok_reg,   ok_next;
    fault_t     code_reg, code_next;

    logic        advance;
    logic [15:0] seg_len;
    marker_act_t act;
    fault_t      raise_code;
    logic        raise;

    // Input register moves on unless a final byte meets a full result register not being read
    assign advance    = in_valid_reg && (!in_final_reg || !out_valid_reg || result_ready);
    assign data_ready = !in_valid_reg || advance;

    assign seg_len = {len_hi_reg, in_byte_reg};

    // Parser next state for the byte in the input register
    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        len_hi_next = len_hi_reg;
        scan_next   = scan_reg;
        eoi_next    = eoi_reg;
        raise       = 1'b0;
        raise_code  = FAULT_OK;
        act         = take_marker(in_byte_reg, scan_reg);
        count_next  = (count_reg < COUNT_W'(MIN_FILE_BYTES)) ? count_reg + 1'b1 : count_reg;

        unique case (phase_reg)
            PH_SOI0:
            begin
                if (in_byte_reg == MARKER_PREFIX) phase_next = PH_SOI1;
                else begin raise = 1'b1; raise_code = FAULT_SOI; end
            end
            PH_SOI1:
            begin
                if (in_byte_reg == MARKER_SOI) phase_next = PH_MARK;
                else begin raise = 1'b1; raise_code = FAULT_SOI; end
            end
            PH_MARK:
            begin
                if (in_byte_reg == MARKER_PREFIX) phase_next = PH_FILL;
                else begin raise = 1'b1; raise_code = FAULT_MARKER; end
            end
            PH_FILL:
            begin
                if (in_byte_reg != MARKER_PREFIX)
                begin
                    phase_next = act.phase;
                    scan_next  = act.scan;
                    eoi_next   = eoi_reg | act.eoi;
                end
            end
            PH_LENHI:
            begin
                len_hi_next = in_byte_reg;
                phase_next  = PH_LENLO;
            end
            PH_LENLO:
            begin
                // length counts its own two bytes
                if (len_hi_reg == 8'd0 && in_byte_reg < 8'd2)
                begin
                    raise      = 1'b1;
                    raise_code = FAULT_LENGTH;
                end else begin
                    remain_next = seg_len - 16'd2;
                    if (seg_len == 16'd2) phase_next = scan_reg ? PH_ENT : PH_MARK;
                    else                  phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                remain_next = remain_reg - 16'd1;
                if (remain_reg == 16'd1) phase_next = scan_reg ? PH_ENT : PH_MARK;
            end
            PH_ENT:
            begin
                if (in_byte_reg == MARKER_PREFIX) phase_next = PH_ENTFF;
            end
            PH_ENTFF:
            begin
                if (in_byte_reg == STUFF_BYTE)         phase_next = PH_ENT;
                else if (in_byte_reg == MARKER_PREFIX) phase_next = PH_FILL;
                else
                begin
                    phase_next = act.phase;
                    scan_next  = act.scan;
                    eoi_next   = eoi_reg | act.eoi;
                end
            end
            PH_DONE:
            begin
                raise      = 1'b1;
                raise_code = FAULT_TRAIL;
            end
            default:
            begin
                phase_next = PH_FAULT;
            end
        endcase

        // keep only the first fault
        fault_next = fault_reg;
        if (raise)
        begin
            phase_next = PH_FAULT;
            if (fault_reg == FAULT_OK) fault_next = raise_code;
        end

        // verdict for a final byte
        if (count_next < COUNT_W'(MIN_FILE_BYTES)) code_next = FAULT_SHORT;
        else if (fault_next != FAULT_OK)           code_next = fault_next;
        else if (eoi_next)                         code_next = FAULT_OK;
        else                                       code_next = FAULT_TRUNC;
        ok_next = (code_next == FAULT_OK);
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end else if (data_ready)
        begin
            in_valid_reg <= data_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_ready && data_valid)
        begin
            in_byte_reg  <= data_byte;
            in_final_reg <= is_final;
        end
    end

    // Parser state, cleared after each verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SOI0;
            count_reg  <= '0;
            remain_reg <= '0;
            len_hi_reg <= '0;
            scan_reg   <= 1'b0;
            fault_reg  <= FAULT_OK;
            eoi_reg    <= 1'b0;
        end else if (advance)
        begin
            if (in_final_reg)
            begin
                phase_reg  <= PH_SOI0;
                count_reg  <= '0;
                remain_reg <= '0;
                len_hi_reg <= '0;
                scan_reg   <= 1'b0;
                fault_reg  <= FAULT_OK;
                eoi_reg    <= 1'b0;
            end else begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                remain_reg <= remain_next;
                len_hi_reg <= len_hi_next;
                scan_reg   <= scan_next;
                fault_reg  <= fault_next;
                eoi_reg    <= eoi_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_final_reg)
        begin
            out_valid_reg <= 1'b1;
        end else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_final_reg)
        begin
            ok_reg   <= ok_next;
            code_reg <= code_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign structure_ok = ok_reg;
    assign fault_code   = code_reg;

    // Checks
    `JMSC_ASSERT_NEXT(a_reset_after_verdict, advance && in_final_reg,
        phase_reg == PH_SOI0 && count_reg == '0 && fault_reg == FAULT_OK,
        "parser not cleared after verdict")
    `JMSC_ASSERT_NOW(a_fault_parks, fault_reg != FAULT_OK, phase_reg == PH_FAULT,
        "fault recorded but parser still running")
    `JMSC_ASSERT_NOW(a_done_has_eoi, phase_reg == PH_DONE, eoi_reg,
        "done phase without EOI")
    `JMSC_ASSERT_NOW(a_ok_matches_code, out_valid_reg, ok_reg == (code_reg == FAULT_OK),
        "verdict flag disagrees with fault code")

endmodule

FILE: bench/tb_jpeg_marker_structure_checker_top.sv
// ----------------------------------------------------------------------------
// tb_jpeg_marker_structure_checker_top
// Self-checking bench for the JPEG marker structure checker.
// ----------------------------------------------------------------------------
// Feeds whole JPEG files byte by byte and predicts the verdict of every file
// with its own parser state. The stimulus starts with hand-built files for
// each fault code, then sends random files, mostly well formed with random
// segments, scans and fill runs, and some truncated, corrupted, padded or
// pure noise. The byte and verdict sides idle at random in several phases,
// and one long verdict hold-off backs the block up into its byte input.
// ----------------------------------------------------------------------------
module tb_jpeg_marker_structure_checker_top;
    timeunit 1ns;
    timeprecision 1ps;
    import jmsc_pkg::*;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT      = 5000;

    // Parser phases of the predictor
    typedef enum logic [3:0] {
        P_SOI_FF,
        P_SOI_D8,
        P_MARK,
        P_FILL,
        P_LEN_HI,
        P_LEN_LO,
        P_SKIP,
        P_ENTROPY,
        P_ENTROPY_FF,
        P_DONE,
        P_FAULT
    } phase_t;

    typedef struct {
        logic   ok;
        fault_t code;
    } verdict_t;

    // Predicts the verdict of each file and checks the verdicts against it
    class marker_verdict_board;
        phase_t    phase;
        bit [2:0]  byte_count;
        bit [15:0] seg_left;
        bit [7:0]  len_hi;
        bit        in_scan;
        fault_t    first_fault;
        bit        saw_eoi;
        verdict_t  pending_verdicts[$];
        int        mismatch_count;

        function new();
            clear_file();
            mismatch_count = 0;
        endfunction

        function void clear_file();
            phase       = P_SOI_FF;
            byte_count  = 3'd0;
            seg_left    = 16'd0;
            len_hi      = 8'd0;
            in_scan     = 1'b0;
            first_fault = FAULT_OK;
            saw_eoi     = 1'b0;
        endfunction

        // only the first fault of a file is kept
        function void flag_fault(fault_t f);
            if (first_fault == FAULT_OK)
            begin
                first_fault = f;
            end
            phase = P_FAULT;
        endfunction

        function void close_segment();
            phase = in_scan ? P_ENTROPY : P_MARK;
        endfunction

        function void enter_marker(logic [7:0] m);
            if (m == MARKER_EOI)
            begin
                saw_eoi = 1'b1;
                phase   = P_DONE;
            end
            else if (m == MARKER_SOS)
            begin
                in_scan = 1'b1;
                phase   = P_LEN_HI;
            end
            else if (m >= MARKER_RST0 && m <= MARKER_RST7)
            begin
                // restart keeps a scan going
                phase = in_scan ? P_ENTROPY : P_MARK;
            end
            else if (m == MARKER_TEM)
            begin
                in_scan = 1'b0;
                phase   = P_MARK;
            end
            else
            begin
                in_scan = 1'b0;
                phase   = P_LEN_HI;
            end
        endfunction

        // Note one accepted byte word; a final byte queues its verdict
        function void take_byte(logic [7:0] b, logic last);
            bit [15:0] seg_len;
            verdict_t  v;
            if (byte_count < 3'(MIN_FILE_BYTES))
            begin
                byte_count++;
            end
            case (phase)
                P_SOI_FF:
                begin
                    if (b == MARKER_PREFIX) phase = P_SOI_D8;
                    else flag_fault(FAULT_SOI);
                end
                P_SOI_D8:
                begin
                    if (b == MARKER_SOI) phase = P_MARK;
                    else flag_fault(FAULT_SOI);
                end
                P_MARK:
                begin
                    if (b == MARKER_PREFIX) phase = P_FILL;
                    else flag_fault(FAULT_MARKER);
                end
                P_FILL:
                begin
                    if (b != MARKER_PREFIX) enter_marker(b);
                end
                P_LEN_HI:
                begin
                    len_hi = b;
                    phase  = P_LEN_LO;
                end
                P_LEN_LO:
                begin
                    seg_len = {len_hi, b};
                    if (seg_len < 16'd2)
                    begin
                        flag_fault(FAULT_LENGTH);
                    end
                    else
                    begin
                        seg_left = seg_len - 16'd2;
                        if (seg_left == 16'd0) close_segment();
                        else phase = P_SKIP;
                    end
                end
                P_SKIP:
                begin
                    seg_left--;
                    if (seg_left == 16'd0) close_segment();
                end
                P_ENTROPY:
                begin
                    if (b == MARKER_PREFIX) phase = P_ENTROPY_FF;
                end
                P_ENTROPY_FF:
                begin
                    if (b == STUFF_BYTE) phase = P_ENTROPY;
                    else if (b == MARKER_PREFIX) phase = P_FILL;
                    else enter_marker(b);
                end
                P_DONE:
                begin
                    flag_fault(FAULT_TRAIL);
                end
                default:
                begin
                    phase = P_FAULT;
                end
            endcase

            if (last)
            begin
                if (byte_count < 3'(MIN_FILE_BYTES)) v.code = FAULT_SHORT;
                else if (first_fault != FAULT_OK) v.code = first_fault;
                else if (saw_eoi) v.code = FAULT_OK;
                else v.code = FAULT_TRUNC;
                v.ok = (v.code == FAULT_OK);
                pending_verdicts.push_back(v);
                clear_file();
            end
        endfunction

        // Compare one accepted verdict word with the oldest prediction
        function void check_verdict(logic ok, logic [2:0] code);
            verdict_t v;
            if (pending_verdicts.size() == 0)
            begin
                $error("verdict with none pending: structure_ok=%0d fault_code=%0d",
                       ok, code);
                mismatch_count++;
                return;
            end
            v = pending_verdicts.pop_front();
            if (ok !== v.ok)
            begin
                $error("structure_ok: expected %0d, got %0d", v.ok, ok);
                mismatch_count++;
            end
            if (code !== v.code)
            begin
                $error("fault_code: expected %0d, got %0d", v.code, code);
                mismatch_count++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       data_valid;
    logic       data_ready;
    logic [7:0] data_byte;
    logic       is_final;
    logic       result_valid;
    logic       result_ready;
    logic       structure_ok;
    logic [2:0] fault_code;

    marker_verdict_board board = new();
    logic [7:0] file_bytes[$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_req       = 1'b0;

    jpeg_marker_structure_checker_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .is_final     (is_final),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .structure_ok (structure_ok),
        .fault_code   (fault_code)
    );

    always #10 clk = ~clk;

    // Watch both channels at each edge
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            board.check_verdict(structure_ok, fault_code);
        end
        if (rst_n && data_valid && data_ready)
        begin
            board.take_byte(data_byte, is_final);
        end
    end

    // Verdict side: random stalls, plus one long hold-off on request
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Drive one byte word and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            data_valid <= 1'b0;
            @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        is_final   <= last;
        @(posedge clk);
        while (!data_ready) @(posedge clk);
    endtask

    task automatic send_file();
        int last_idx;
        last_idx = file_bytes.size() - 1;
        for (int i = 0; i <= last_idx; i++)
        begin
            send_byte(file_bytes[i], i == last_idx);
        end
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // Any marker that carries a length, excluding SOS
    function automatic logic [7:0] pick_plain_marker();
        logic [7:0] m;
        do
        begin
            m = 8'($urandom_range(254));
        end
        while (m == MARKER_TEM || m == MARKER_EOI || m == MARKER_SOS ||
               (m >= MARKER_RST0 && m <= MARKER_RST7));
        return m;
    endfunction

    // Marker with an optional fill run in front
    function automatic void put_marker(logic [7:0] m);
        repeat ($urandom_range(2)) file_bytes.push_back(MARKER_PREFIX);
        file_bytes.push_back(MARKER_PREFIX);
        file_bytes.push_back(m);
    endfunction

    function automatic void add_segment(logic [7:0] m, int payload);
        logic [15:0] seg_len;
        seg_len = 16'(payload + 2);
        put_marker(m);
        file_bytes.push_back(seg_len[15:8]);
        file_bytes.push_back(seg_len[7:0]);
        repeat (payload) file_bytes.push_back(rand_byte());
    endfunction

    // SOS header then entropy data with stuffing, restarts and fill runs
    function automatic void add_scan();
        int r;
        add_segment(MARKER_SOS, $urandom_range(6));
        repeat ($urandom_range(30))
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                file_bytes.push_back(MARKER_PREFIX);
                file_bytes.push_back(STUFF_BYTE);
            end
            else if (r < 21)
            begin
                if (r >= 18) repeat ($urandom_range(1, 2)) file_bytes.push_back(MARKER_PREFIX);
                file_bytes.push_back(MARKER_PREFIX);
                file_bytes.push_back(8'(MARKER_RST0 + $urandom_range(7)));
            end
            else
            begin
                file_bytes.push_back(8'($urandom_range(254)));
            end
        end
    endfunction

    function automatic void build_good_file();
        int r;
        file_bytes.delete();
        file_bytes.push_back(MARKER_PREFIX);
        file_bytes.push_back(MARKER_SOI);
        repeat ($urandom_range(4))
        begin
            r = $urandom_range(99);
            if (r < 40) add_segment(pick_plain_marker(), $urandom_range(12));
            else if (r < 55)
                put_marker($urandom_range(1) ? MARKER_TEM : 8'(MARKER_RST0 + $urandom_range(7)));
            else if (r < 95) add_scan();
            else add_segment(pick_plain_marker(), 254 + $urandom_range(40));
        end
        put_marker(MARKER_EOI);
    endfunction

    // Truncated, corrupted, padded, bad-length or pure noise files
    function automatic void build_broken_file();
        int r;
        int n;
        r = $urandom_range(99);
        build_good_file();
        if (r < 25)
        begin
            n = $urandom_range(file_bytes.size() - 1, 1);
            while (file_bytes.size() > n) void'(file_bytes.pop_back());
        end
        else if (r < 45)
        begin
            file_bytes[$urandom_range(file_bytes.size() - 1)] = rand_byte();
        end
        else if (r < 60)
        begin
            repeat ($urandom_range(1, 3)) file_bytes.push_back(rand_byte());
        end
        else if (r < 80)
        begin
            file_bytes.delete();
            file_bytes.push_back(MARKER_PREFIX);
            file_bytes.push_back(MARKER_SOI);
            put_marker($urandom_range(3) == 0 ? MARKER_SOS : pick_plain_marker());
            file_bytes.push_back(8'd0);
            file_bytes.push_back(8'($urandom_range(1)));
            put_marker(MARKER_EOI);
        end
        else
        begin
            file_bytes.delete();
            repeat ($urandom_range(1, 12)) file_bytes.push_back(rand_byte());
        end
    endfunction

    // Main sequence
    initial
    begin
        int idle_plan[4];
        int stall_plan[4];
        int phase_bytes;
        int phase_files;
        int drain_cycles;

        idle_plan  = '{0, 54, 0, 7};
        stall_plan = '{0, 0, 54, 7};
        rst_n      = 1'b0;
        data_valid = 1'b0;
        data_byte  = 8'd0;
        is_final   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hand-built files while the verdict side holds off
        hold_req = 1'b1;
        file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hD9};
        send_file();
        file_bytes = '{8'hFF};
        send_file();
        file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hFF, 8'hD9};
        send_file();
        file_bytes = '{8'h00, 8'hFF, 8'hD8, 8'hFF, 8'hD9};
        send_file();
        file_bytes = '{8'hFF, 8'hFF, 8'hD8, 8'hFF, 8'hD9};
        send_file();
        file_bytes = '{8'hFF, 8'hD8, 8'h7F, 8'hFF, 8'hD9};
        send_file();
        file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h01, 8'hFF, 8'hD9};
        send_file();
        file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hD9, 8'h00};
        send_file();
        file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h05, 8'hAA};
        send_file();
        // standalone markers, stuffing, restart and fill run inside a scan
        file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'h01, 8'hFF, 8'hD0, 8'hFF, 8'hDA,
                       8'h00, 8'h02, 8'hFF, 8'h00, 8'hFF, 8'hD3, 8'h12, 8'hFF,
                       8'hFF, 8'hD7, 8'hFF, 8'hD9};
        send_file();
        // segment length with a low byte below 2 but a nonzero high byte
        file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hC4, 8'h01, 8'h00};
        repeat (254) file_bytes.push_back(rand_byte());
        file_bytes.push_back(MARKER_PREFIX);
        file_bytes.push_back(MARKER_EOI);
        send_file();

        // random files over the idling phases
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            phase_bytes    = 0;
            phase_files    = 0;
            while (phase_bytes < 400 || phase_files < 8)
            begin
                if ($urandom_range(99) < 75) build_good_file();
                else build_broken_file();
                phase_bytes += file_bytes.size();
                phase_files++;
                send_file();
            end
        end
        data_valid <= 1'b0;

        // drain the verdicts still in flight
        recv_stall_pct = 0;
        drain_cycles   = 0;
        while (board.pending_verdicts.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (8) @(posedge clk);

        if (board.pending_verdicts.size() != 0)
        begin
            $error("%0d verdicts never arrived", board.pending_verdicts.size());
            board.mismatch_count++;
        end
        if (board.mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
